>>> rtl/fsp_pkg.sv
// ----------------------------------------------------------------------------
// fsp_pkg: shared types and constants for the palette remapper
// Holds the channel payload types, the register and op codes, the sequencer
// states and the diffusion constants.
// ----------------------------------------------------------------------------
package fsp_pkg;

    localparam int MAX_WIDTH_DEF     = 1024;
    localparam int PALETTE_DEPTH_DEF = 256;

    // Op codes of an input item
    localparam logic [1:0] OP_PIXEL    = 2'd0;
    localparam logic [1:0] OP_LOAD_SRC = 2'd1;
    localparam logic [1:0] OP_LOAD_TGT = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_LINE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SOURCE_SIZE = 2'd1;
    localparam logic [1:0] CFG_TARGET_SIZE = 2'd2;

    localparam logic [10:0] LINE_WIDTH_RST = 11'd64;
    localparam logic [8:0]  SIZE_RST       = 9'd256;

    // Diffusion weights in sixteenths and rounding
    localparam logic [3:0] K_RIGHT       = 4'd7;
    localparam logic [3:0] K_BELOW_LEFT  = 4'd3;
    localparam logic [3:0] K_BELOW       = 4'd5;
    localparam logic [3:0] K_BELOW_RIGHT = 4'd1;
    localparam int         ROUND_BIAS    = 8;
    localparam int         SHARE_SHIFT   = 4;
    localparam int         CH_MAX        = 255;

    // Colour word: index 2 red, 1 green, 0 blue
    typedef logic [2:0][7:0] rgb_t;
    // Error word: three signed 12-bit channels, same order
    typedef logic [2:0][11:0] err_px_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_start;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] target_index;
        logic       row_end;
    } pix_out_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [10:0] value;
    } cfg_wr_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SRC_RD,
        ST_ADJ,
        ST_SEARCH,
        ST_ERR,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_OUT
    } fsp_state_t;

endpackage

>>> rtl/fsp_if.sv
// ----------------------------------------------------------------------------
// fsp_if: channel interfaces of the palette remapper
// Valid/ready channels for pixel input, result output and register writes.
// ----------------------------------------------------------------------------
interface fsp_pix_in_if import fsp_pkg::*; ();
    logic    valid;
    logic    ready;
    pix_in_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fsp_pix_out_if import fsp_pkg::*; ();
    logic     valid;
    logic     ready;
    pix_out_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fsp_cfg_if import fsp_pkg::*; ();
    logic    valid;
    logic    ready;
    cfg_wr_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/floyd_steinberg_palette_remap.sv
// ----------------------------------------------------------------------------
// floyd_steinberg_palette_remap: palette remap with error diffusion
// Maps source-indexed pixels onto a target palette, spreading the quantizing
// error over two row error stores in the 7/3/5/1 sixteenths pattern.
// ----------------------------------------------------------------------------
//
//  channel   dir   payload                                   transaction
//  --------  ----  ----------------------------------------  ----------------------
//  cfg       in    index, value                              register write
//  pix_in    in    op, entry_index, red, green, blue,        pixel or palette load
//                  frame_start
//  pix_out   out   target_index, row_end                     one per pixel
//
//  For a pixel, the nearest-colour search reads one target entry per cycle
//  from the single-port palette memory, then up to four read-modify-write
//  passes hit the error stores. A palette load is written as it is accepted.
//  The last pixel of a row adds a clearing pass over the retired row store;
//  a frame start pixel adds one over both stores, as does reset.
//  A stalled result holds in the output register; the next pixel is accepted
//  meanwhile and waits only at its own result. Register writes are always
//  taken.
//
module floyd_steinberg_palette_remap import fsp_pkg::*; #(
    parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input logic            clk,
    input logic            rst_n,
    fsp_cfg_if.sink        cfg,
    fsp_pix_in_if.sink     pix_in,
    fsp_pix_out_if.source  pix_out
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int PAW = $clog2(PALETTE_DEPTH);
    localparam int SW  = PAW + 1;
    localparam int LWB = $clog2(MAX_WIDTH + 1);
    localparam int CW  = (LWB > 11) ? LWB : 11;
    localparam int DW  = 18;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    fsp_state_t        state_reg, state_next;

    logic [10:0]       line_width_reg;
    logic [8:0]        src_size_reg;
    logic [8:0]        tgt_size_reg;

    logic [7:0]        idx_reg;
    logic [AW-1:0]     x_reg;
    logic              last_reg;
    logic [AW-1:0]     column_reg;
    logic              cur_bank_reg;
    logic [1:0]        clr_mask_reg;
    logic [AW-1:0]     clr_cnt_reg;
    logic              pending_reg;
    logic [1:0]        step_reg;

    logic [7:0]        adj_reg [3];
    logic signed [8:0] e_reg [3];

    logic [SW-1:0]     srch_i_reg;
    logic              p1_valid_reg;
    logic [PAW-1:0]    p1_idx_reg;
    logic              p2_valid_reg;
    logic [PAW-1:0]    p2_idx_reg;
    logic [DW-1:0]     p2_d_reg;
    rgb_t              p2_rgb_reg;
    logic [PAW-1:0]    best_reg;
    logic [DW-1:0]     best_d_reg;
    rgb_t              best_rgb_reg;

    logic              out_valid_reg;
    pix_out_t          out_data_reg;

    // Memories and their read registers
    rgb_t              src_mem [PALETTE_DEPTH];
    rgb_t              tgt_mem [PALETTE_DEPTH];
    rgb_t              src_rdata;
    rgb_t              tgt_rdata;
    err_px_t           bank_rdata [2];

    // ------------------------------------------------------------------
    // Combinational control
    // ------------------------------------------------------------------
    logic              in_acc;
    logic              out_free;
    logic              clr_done;
    logic [CW-1:0]     w_c, x_c, lw_ext, col_ext;
    logic [AW-1:0]     x_ca;
    logic              last_c;
    logic [SW-1:0]     tsize_c;
    logic              src_ok;
    logic              srch_issue;
    logic              srch_done;
    logic              src_re, tgt_re, src_we, tgt_we;
    logic [PAW-1:0]    tgt_addr;
    logic              bank_re [2];
    logic              bank_we [2];
    logic [AW-1:0]     bank_addr [2];
    err_px_t           bank_wdata [2];

    logic              step_sel;
    logic              step_en;
    logic [AW-1:0]     step_addr;
    logic [3:0]        step_k;
    logic              step_bank;
    err_px_t           upd_word;
    logic [DW-1:0]     sq_dist;

    function automatic logic signed [8:0] share(input logic signed [8:0] e,
                                                input logic [3:0] k);
        logic signed [12:0] p;
        p = 13'(e) * 13'($signed({1'b0, k}));
        p = p + 13'(ROUND_BIAS);
        return 9'(p >>> SHARE_SHIFT);
    endfunction

    assign in_acc   = pix_in.valid && pix_in.ready;
    assign out_free = !out_valid_reg || pix_out.ready;
    assign clr_done = (clr_cnt_reg == AW'(MAX_WIDTH - 1));

    // Clamp the row width and the column into range
    always_comb
    begin
        lw_ext  = CW'(line_width_reg);
        col_ext = CW'(column_reg);
        if (lw_ext == '0)
            w_c = CW'(1);
        else if (lw_ext > CW'(MAX_WIDTH))
            w_c = CW'(MAX_WIDTH);
        else
            w_c = lw_ext;
        x_c    = (col_ext >= w_c) ? (w_c - CW'(1)) : col_ext;
        x_ca   = x_c[AW-1:0];
        last_c = ((x_c + CW'(1)) >= w_c);
    end

    always_comb
    begin
        if (tgt_size_reg == '0)
            tsize_c = SW'(1);
        else if (tgt_size_reg > 9'(PALETTE_DEPTH))
            tsize_c = SW'(PALETTE_DEPTH);
        else
            tsize_c = SW'(tgt_size_reg);
    end

    // A source index out of range counts as colour zero
    assign src_ok = ({1'b0, idx_reg} < src_size_reg) &&
                    ({1'b0, idx_reg} < 9'(PALETTE_DEPTH));

    assign srch_issue = (state_reg == ST_SEARCH) && (srch_i_reg < tsize_c);
    assign srch_done  = !srch_issue && !p1_valid_reg && !p2_valid_reg;

    // Diffusion steps: right, below-right, below-left, below
    always_comb
    begin
        step_sel  = 1'b1;
        step_en   = 1'b1;
        step_addr = x_reg;
        step_k    = K_BELOW;
        case (step_reg)
            2'd0:
            begin
                step_sel  = 1'b0;
                step_en   = !last_reg;
                step_addr = AW'({1'b0, x_reg} + 1'b1);
                step_k    = K_RIGHT;
            end
            2'd1:
            begin
                step_en   = !last_reg;
                step_addr = AW'({1'b0, x_reg} + 1'b1);
                step_k    = K_BELOW_RIGHT;
            end
            2'd2:
            begin
                step_en   = (x_reg != '0);
                step_addr = x_reg - AW'(1);
                step_k    = K_BELOW_LEFT;
            end
            default:
            begin
                step_en   = 1'b1;
                step_addr = x_reg;
                step_k    = K_BELOW;
            end
        endcase
        step_bank = cur_bank_reg ^ step_sel;
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            upd_word[c] = bank_rdata[step_bank][c] + 12'(share(e_reg[c], step_k));
    end

    // Squared distance of the adjusted colour to the target entry just read
    always_comb
    begin
        logic signed [9:0]  df;
        logic signed [19:0] sq;
        sq_dist = '0;
        for (int c = 0; c < 3; c++)
        begin
            df      = $signed({2'b0, adj_reg[c]}) - $signed({2'b0, tgt_rdata[c]});
            sq      = df * df;
            sq_dist = sq_dist + DW'($unsigned(sq));
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_done)
                    state_next = pending_reg ? ST_SRC_RD : ST_IDLE;
            ST_IDLE:
                if (in_acc && pix_in.data.op == OP_PIXEL)
                    state_next = pix_in.data.frame_start ? ST_CLEAR : ST_SRC_RD;
            ST_SRC_RD: state_next = ST_ADJ;
            ST_ADJ:    state_next = ST_SEARCH;
            ST_SEARCH:
                if (srch_done)
                    state_next = ST_ERR;
            ST_ERR:    state_next = ST_UPD_RD;
            ST_UPD_RD:
                if (step_en)
                    state_next = ST_UPD_WR;
                else if (step_reg == 2'd3)
                    state_next = ST_OUT;
            ST_UPD_WR:
                state_next = (step_reg == 2'd3) ? ST_OUT : ST_UPD_RD;
            ST_OUT:
                if (out_free)
                    state_next = last_reg ? ST_CLEAR : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs (memory strobes, handshakes)
    // ------------------------------------------------------------------
    always_comb
    begin
        pix_in.ready = (state_reg == ST_IDLE);
        src_we   = 1'b0;
        tgt_we   = 1'b0;
        src_re   = 1'b0;
        tgt_re   = 1'b0;
        tgt_addr = srch_i_reg[PAW-1:0];
        for (int b = 0; b < 2; b++)
        begin
            bank_re[b]    = 1'b0;
            bank_we[b]    = 1'b0;
            bank_addr[b]  = clr_cnt_reg;
            bank_wdata[b] = '0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                for (int b = 0; b < 2; b++)
                    bank_we[b] = clr_mask_reg[b];
            end
            ST_IDLE:
            begin
                if (in_acc && ({1'b0, pix_in.data.entry_index} < 9'(PALETTE_DEPTH)))
                begin
                    src_we = (pix_in.data.op == OP_LOAD_SRC);
                    tgt_we = (pix_in.data.op == OP_LOAD_TGT);
                end
                tgt_addr = pix_in.data.entry_index[PAW-1:0];
            end
            ST_SRC_RD:
            begin
                src_re                  = 1'b1;
                bank_re[cur_bank_reg]   = 1'b1;
                bank_addr[cur_bank_reg] = x_ca;
            end
            ST_SEARCH:
                tgt_re = srch_issue;
            ST_UPD_RD:
            begin
                bank_re[step_bank]   = step_en;
                bank_addr[step_bank] = step_addr;
            end
            ST_UPD_WR:
            begin
                bank_we[step_bank]    = 1'b1;
                bank_addr[step_bank]  = step_addr;
                bank_wdata[step_bank] = upd_word;
            end
            default:
            begin
            end
        endcase
    end

    assign cfg.ready     = 1'b1;
    assign pix_out.valid = out_valid_reg;
    assign pix_out.data  = out_data_reg;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (src_we)
            src_mem[pix_in.data.entry_index[PAW-1:0]] <=
                {pix_in.data.red, pix_in.data.green, pix_in.data.blue};
        if (src_re)
            src_rdata <= src_mem[idx_reg[PAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (tgt_we)
            tgt_mem[tgt_addr] <= {pix_in.data.red, pix_in.data.green, pix_in.data.blue};
        if (tgt_re)
            tgt_rdata <= tgt_mem[tgt_addr];
    end

    for (genvar b = 0; b < 2; b++)
    begin : gen_bank
        err_px_t err_mem [MAX_WIDTH];
        always_ff @(posedge clk)
        begin
            if (bank_we[b])
                err_mem[bank_addr[b]] <= bank_wdata[b];
            if (bank_re[b])
                bank_rdata[b] <= err_mem[bank_addr[b]];
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RST;
            src_size_reg   <= SIZE_RST;
            tgt_size_reg   <= SIZE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.index)
                CFG_LINE_WIDTH:  line_width_reg <= cfg.data.value;
                CFG_SOURCE_SIZE: src_size_reg   <= cfg.data.value[8:0];
                CFG_TARGET_SIZE: tgt_size_reg   <= cfg.data.value[8:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_mask_reg  <= 2'b11;
            clr_cnt_reg   <= '0;
            pending_reg   <= 1'b0;
            cur_bank_reg  <= 1'b0;
            column_reg    <= '0;
            step_reg      <= '0;
            srch_i_reg    <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Load a new result, or release the held one once the sink takes it
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && pix_out.ready)
                out_valid_reg <= 1'b0;

            p1_valid_reg <= srch_issue;
            p2_valid_reg <= p1_valid_reg;
            if (srch_issue)
                srch_i_reg <= srch_i_reg + SW'(1);

            case (state_reg)
                ST_CLEAR:
                    clr_cnt_reg <= clr_done ? '0 : clr_cnt_reg + AW'(1);
                ST_IDLE:
                    if (in_acc && pix_in.data.op == OP_PIXEL && pix_in.data.frame_start)
                    begin
                        // Frame start: wipe both stores, restart at bank zero
                        clr_mask_reg <= 2'b11;
                        clr_cnt_reg  <= '0;
                        pending_reg  <= 1'b1;
                        cur_bank_reg <= 1'b0;
                        column_reg   <= '0;
                    end
                ST_ADJ:
                    srch_i_reg <= '0;
                ST_ERR:
                    step_reg <= '0;
                ST_UPD_RD:
                    if (!step_en)
                        step_reg <= step_reg + 2'd1;
                ST_UPD_WR:
                    step_reg <= step_reg + 2'd1;
                ST_OUT:
                    if (out_free)
                    begin
                        if (last_reg)
                        begin
                            // Swap row stores and clear the retired one
                            column_reg   <= '0;
                            cur_bank_reg <= !cur_bank_reg;
                            clr_mask_reg <= cur_bank_reg ? 2'b10 : 2'b01;
                            clr_cnt_reg  <= '0;
                            pending_reg  <= 1'b0;
                        end
                        else
                            column_reg <= AW'({1'b0, x_reg} + 1'b1);
                    end
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        p1_idx_reg <= srch_i_reg[PAW-1:0];
        p2_idx_reg <= p1_idx_reg;
        p2_rgb_reg <= tgt_rdata;
        p2_d_reg   <= sq_dist;

        if (in_acc)
            idx_reg <= pix_in.data.entry_index;

        if (state_reg == ST_SRC_RD)
        begin
            x_reg    <= x_ca;
            last_reg <= last_c;
        end

        if (state_reg == ST_ADJ)
        begin
            logic        [7:0]  base;
            logic signed [12:0] s;
            for (int c = 0; c < 3; c++)
            begin
                base = src_ok ? src_rdata[c] : 8'd0;
                s    = $signed({5'b0, base}) +
                       $signed({bank_rdata[cur_bank_reg][c][11], bank_rdata[cur_bank_reg][c]});
                if (s < 0)
                    adj_reg[c] <= 8'd0;
                else if (s > 13'sd255)
                    adj_reg[c] <= 8'(CH_MAX);
                else
                    adj_reg[c] <= s[7:0];
            end
            best_d_reg <= '1;
            best_reg   <= '0;
        end

        // Keep the first entry of the lowest distance
        if (p2_valid_reg && (p2_d_reg < best_d_reg))
        begin
            best_d_reg   <= p2_d_reg;
            best_reg     <= p2_idx_reg;
            best_rgb_reg <= p2_rgb_reg;
        end

        if (state_reg == ST_ERR)
        begin
            for (int c = 0; c < 3; c++)
                e_reg[c] <= 9'($signed({2'b0, adj_reg[c]}) -
                               $signed({2'b0, best_rgb_reg[c]}));
        end

        if (state_reg == ST_OUT && out_free)
        begin
            out_data_reg.target_index <= 8'(best_reg);
            out_data_reg.row_end      <= last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pix_out.valid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output step");

    a_pixel_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && pix_in.data.op == OP_PIXEL) |=> (state_reg != ST_IDLE))
        else $error("pixel transaction did not start the sequencer");

    a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
        column_reg <= AW'(MAX_WIDTH - 1))
        else $error("column beyond row store");

    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ERR) |-> (SW'(best_reg) < tsize_c))
        else $error("chosen target entry outside searched range");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the error-diffusion palette remapper
// Feeds palette loads and raster pixels, predicts the chosen target index and
// row end of each pixel with a behavioral dither model, and compares results.
// ----------------------------------------------------------------------------
module tb_top;
    import fsp_pkg::*;

    localparam int MAXW  = MAX_WIDTH_DEF;
    localparam int DEPTH = PALETTE_DEPTH_DEF;
    localparam longint CYCLE_LIMIT = 3_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fsp_cfg_if    cfg_ch();
    fsp_pix_in_if pin_ch();
    fsp_pix_out_if pout_ch();

    floyd_steinberg_palette_remap dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch.sink),
        .pix_in (pin_ch.sink),
        .pix_out(pout_ch.source)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Dither model state: palettes, two error banks, column, registers
    // ------------------------------------------------------------------
    rgb_t    src_pal [DEPTH];
    rgb_t    tgt_pal [DEPTH];
    bit      src_written [DEPTH];
    bit      tgt_written [DEPTH];
    int      err_bank [2][MAXW][3];
    int      live_bank;
    int      col_pos;
    int      width_reg;
    int      src_size_reg;
    int      tgt_size_reg;

    pix_in_t  pending_items [$];
    pix_out_t remap_expected [$];
    int       error_count;
    int       results_seen;
    int       pixels_sent;
    int       loads_sent;
    longint   cycle_count;
    bit       stim_done;
    bit       hold_off_req;

    function automatic int diffuse_share(int e, int k);
        return (e * k + 8) >>> 4;
    endfunction

    function automatic void clear_errors();
        foreach (err_bank[b, x, c])
            err_bank[b][x][c] = 0;
    endfunction

    // Work out one item's effect on the model; queue the result of a pixel.
    function automatic void predict_remap(pix_in_t it);
        int w, x, t, best, nb;
        int adj[3];
        int e[3];
        int bestd, d;
        bit last;
        if (it.op == OP_LOAD_SRC || it.op == OP_LOAD_TGT)
        begin
            if (it.op == OP_LOAD_SRC)
                src_pal[it.entry_index] = {it.red, it.green, it.blue};
            else
                tgt_pal[it.entry_index] = {it.red, it.green, it.blue};
            return;
        end
        if (it.op != OP_PIXEL)
            return;
        if (it.frame_start)
        begin
            clear_errors();
            live_bank = 0;
            col_pos = 0;
        end
        w = (width_reg < 1) ? 1 : (width_reg > MAXW ? MAXW : width_reg);
        x = (col_pos >= w) ? w - 1 : col_pos;
        last = (x + 1 >= w);
        nb = live_bank ^ 1;
        for (int c = 0; c < 3; c++)
        begin
            int base;
            base = (it.entry_index < src_size_reg) ? int'(src_pal[it.entry_index][2 - c]) : 0;
            adj[c] = base + err_bank[live_bank][x][c];
            if (adj[c] < 0) adj[c] = 0;
            if (adj[c] > 255) adj[c] = 255;
        end
        t = (tgt_size_reg < 1) ? 1 : (tgt_size_reg > DEPTH ? DEPTH : tgt_size_reg);
        best = 0;
        bestd = 32'h7fff_ffff;
        for (int i = 0; i < t; i++)
        begin
            d = 0;
            for (int c = 0; c < 3; c++)
                d += (adj[c] - int'(tgt_pal[i][2 - c])) * (adj[c] - int'(tgt_pal[i][2 - c]));
            if (d < bestd)
            begin
                bestd = d;
                best = i;
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            e[c] = adj[c] - int'(tgt_pal[best][2 - c]);
            if (!last)
            begin
                err_bank[live_bank][x + 1][c] += diffuse_share(e[c], 7);
                err_bank[nb][x + 1][c] += diffuse_share(e[c], 1);
            end
            if (x > 0)
                err_bank[nb][x - 1][c] += diffuse_share(e[c], 3);
            err_bank[nb][x][c] += diffuse_share(e[c], 5);
        end
        if (last)
        begin
            for (int i = 0; i < MAXW; i++)
                for (int c = 0; c < 3; c++)
                    err_bank[live_bank][i][c] = 0;
            live_bank = nb;
            col_pos = 0;
        end
        else
            col_pos = x + 1;
        remap_expected.push_back('{target_index: best[7:0], row_end: last});
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0)
            return 0;
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued items, predicting each one as it is accepted
    // ------------------------------------------------------------------
    int drv_gap;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_ch.valid <= 1'b0;
            pin_ch.data <= '0;
            drv_gap = 0;
        end
        else
        begin
            // retire the accepted transaction first
            if (pin_ch.valid && pin_ch.ready)
            begin
                predict_remap(pin_ch.data);
                void'(pending_items.pop_front());
                drv_gap = pick_gap();
            end
            if (pin_ch.valid && !pin_ch.ready)
                ;   // hold the offered item
            else if (drv_gap > 0)
            begin
                drv_gap--;
                pin_ch.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                pin_ch.valid <= 1'b1;
                pin_ch.data <= pending_items[0];
            end
            else
                pin_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, compare against the oldest expectation
    // ------------------------------------------------------------------
    int mon_gap;
    int hold_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pout_ch.ready <= 1'b0;
            mon_gap = 0;
            hold_left = 0;
        end
        else
        begin
            if (pout_ch.valid && pout_ch.ready)
            begin
                results_seen++;
                if (remap_expected.size() == 0)
                    report_mismatch("unexpected result, index",
                                    int'(pout_ch.data.target_index), -1);
                else
                begin
                    pix_out_t want;
                    want = remap_expected.pop_front();
                    if (pout_ch.data.target_index !== want.target_index)
                        report_mismatch("target_index", int'(pout_ch.data.target_index),
                                        int'(want.target_index));
                    if (pout_ch.data.row_end !== want.row_end)
                        report_mismatch("row_end", int'(pout_ch.data.row_end),
                                        int'(want.row_end));
                end
            end
            if (hold_off_req && hold_left == 0)
            begin
                hold_off_req = 1'b0;
                hold_left = 6000;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pout_ch.ready <= 1'b0;
            end
            else if (mon_gap > 0)
            begin
                mon_gap--;
                pout_ch.ready <= 1'b0;
            end
            else
            begin
                pout_ch.ready <= 1'b1;
                mon_gap = pick_gap();
            end
        end
    end

    // Generous run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic pix_in_t make_load(logic [1:0] op, int slot, rgb_t c);
        pix_in_t it;
        it.op = op;
        it.entry_index = slot[7:0];
        it.red = c[2];
        it.green = c[1];
        it.blue = c[0];
        it.frame_start = 1'b0;
        if (op == OP_LOAD_SRC) src_written[slot] = 1'b1;
        else tgt_written[slot] = 1'b1;
        return it;
    endfunction

    // Pixel whose index is either unwritten-safe: valid written entry or beyond size
    function automatic pix_in_t make_pixel(int idx, bit fs);
        pix_in_t it;
        it = '0;
        it.op = OP_PIXEL;
        it.entry_index = idx[7:0];
        it.red = 8'($urandom());
        it.green = 8'($urandom());
        it.blue = 8'($urandom());
        it.frame_start = fs;
        return it;
    endfunction

    function automatic int pick_src_index();
        int idx;
        idx = $urandom_range(0, 255);
        if (idx < src_size_reg && !src_written[idx])
            idx = (src_size_reg < 256) ? $urandom_range(src_size_reg, 255) : 0;
        return idx;
    endfunction

    function automatic rgb_t random_colour();
        case ($urandom_range(0, 4))
            0: return 24'h000000;
            1: return 24'hffffff;
            default: return 24'($urandom());
        endcase
    endfunction

    task automatic wait_drained(int settle);
        while (pending_items.size() > 0 || remap_expected.size() > 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Register write while the block is idle
    task automatic write_reg(logic [1:0] index, int value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= '{index: index, value: value[10:0]};
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        case (index)
            CFG_LINE_WIDTH:  width_reg = value & 11'h7ff;
            CFG_SOURCE_SIZE: src_size_reg = value & 9'h1ff;
            default:         tgt_size_reg = value & 9'h1ff;
        endcase
    endtask

    task automatic run_phase(int w, int ssz, int tsz, int npix);
        wait_drained(2 * MAXW + 400);
        write_reg(CFG_LINE_WIDTH, w);
        write_reg(CFG_SOURCE_SIZE, ssz);
        write_reg(CFG_TARGET_SIZE, tsz);
        // the search only reaches written target entries
        for (int i = 0; i < DEPTH; i++)
            if (!tgt_written[i])
                pending_items.push_back(make_load(OP_LOAD_TGT, i, random_colour()));
        for (int i = 0; i < npix; i++)
        begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 3)
                pending_items.push_back(make_load(OP_LOAD_SRC, $urandom_range(0, 255),
                                                  random_colour()));
            else if (r < 5)
                pending_items.push_back(make_load(OP_LOAD_TGT, $urandom_range(0, 255),
                                                  random_colour()));
            else if (r < 6)
            begin
                pix_in_t junk;
                junk = make_pixel($urandom_range(0, 255), 1'b0);
                junk.op = 2'd3;   // unknown op: dropped
                pending_items.push_back(junk);
            end
            else
            begin
                pending_items.push_back(make_pixel(pick_src_index(), i == 0 || r == 99));
                pixels_sent++;
            end
        end
    endtask

    initial
    begin
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        pin_ch.valid = 1'b0;
        pin_ch.data = '0;
        pout_ch.ready = 1'b0;
        width_reg = LINE_WIDTH_RST;
        src_size_reg = SIZE_RST;
        tgt_size_reg = SIZE_RST;
        live_bank = 0;
        col_pos = 0;
        clear_errors();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (MAXW + 20) @(posedge clk);

        // Directed: fill both palettes, then the extremes
        for (int i = 0; i < DEPTH; i++)
        begin
            pending_items.push_back(make_load(OP_LOAD_SRC, i, random_colour()));
            pending_items.push_back(make_load(OP_LOAD_TGT, i, random_colour()));
        end
        pending_items.push_back(make_load(OP_LOAD_SRC, 0, 24'h000000));
        pending_items.push_back(make_load(OP_LOAD_SRC, 255, 24'hffffff));
        pending_items.push_back(make_load(OP_LOAD_TGT, 0, 24'h808080));
        pending_items.push_back(make_load(OP_LOAD_TGT, 1, 24'h808080));   // tie, lowest wins
        pending_items.push_back(make_load(OP_LOAD_TGT, 255, 24'hffffff));
        pending_items.push_back(make_pixel(0, 1'b1));
        pending_items.push_back(make_pixel(255, 1'b0));
        pending_items.push_back(make_pixel(128, 1'b0));
        pending_items.push_back(make_pixel(255, 1'b1));

        // Widths out of range, shrink mid-row, size extremes
        run_phase(3, 16, 4, 20);
        run_phase(0, 0, 0, 12);          // width and target size act as 1
        run_phase(5, 256, 256, 3);
        run_phase(2, 256, 256, 4);       // shrink mid-row: row ends at once
        run_phase(2047, 511, 511, 15);   // saturate width and target size
        run_phase(1, 200, 1, 15);
        // Long back-pressure while pixels keep coming
        run_phase(8, 256, 8, 40);
        hold_off_req = 1'b1;
        run_phase(16, 128, 32, 180);
        run_phase(6, 256, 16, 180);
        run_phase(1024, 256, 8, 100);
        run_phase(7, 64, 256, 60);
        run_phase(33, 256, 64, 180);
        run_phase(LINE_WIDTH_RST, SIZE_RST, SIZE_RST, 20);

        wait_drained(2 * MAXW + 400);
        $display("covered %0d pixels, %0d palette loads and register phases from 0 to full range",
                 pixels_sent, loads_sent);
        $display("%0d results compared, %0d mismatches", results_seen, error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Count loads as they are accepted
    always @(posedge clk)
        if (rst_n && pin_ch.valid && pin_ch.ready &&
            (pin_ch.data.op == OP_LOAD_SRC || pin_ch.data.op == OP_LOAD_TGT))
            loads_sent++;

endmodule

>>> files.f
rtl/fsp_pkg.sv
rtl/fsp_if.sv
rtl/floyd_steinberg_palette_remap.sv
sim/tb_top.sv
